// File: design/bfps_pkg.sv
// Shared types and constants for the byte ring FIFO with peek and skip.
package bfps_pkg;

   localparam int CMD_W  = 3;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 7;
   localparam int OFF_W  = 10;
   localparam int LVL_W  = 11;
   localparam int FILL_W = 2;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [OFF_W-1:0]  offset_type;
   typedef logic [LVL_W-1:0]  level_type;
   typedef logic [FILL_W-1:0] fill_type;

   localparam cmd_type CMD_PUT    = cmd_type'(0);
   localparam cmd_type CMD_GET    = cmd_type'(1);
   localparam cmd_type CMD_PEEK   = cmd_type'(2);
   localparam cmd_type CMD_SKIP   = cmd_type'(3);
   localparam cmd_type CMD_RESET  = cmd_type'(4);
   localparam cmd_type CMD_STATUS = cmd_type'(5);

   localparam fill_type FILL_EMPTY   = fill_type'(0);
   localparam fill_type FILL_PARTIAL = fill_type'(1);
   localparam fill_type FILL_FULL    = fill_type'(2);

   typedef struct packed {
      cmd_type    command;
      data_type   data_in;
      count_type  count;
      offset_type offset;
   } req_type;

   typedef struct packed {
      data_type  data_out;
      logic      data_valid;
      logic      last;
      count_type done_count;
      level_type level;
      fill_type  fill_state;
   } rsp_type;

endpackage

// File: design/byte_ring_fifo_peek_skip.sv
// Top level: byte ring FIFO with put, get, peek, skip, reset and status requests.
//
// A request is taken when start is high and busy is low. Put, skip, reset and
// status give a single result on the next cycle, so a byte stream can be put at
// one byte per cycle. Get and peek of n bytes (n at most MAX_BURST) hold busy
// while the n bytes are read and deliver one byte per cycle; each byte passes
// the state register and then the read data register of the byte memory, whose
// single read port sets that pace. A get or peek that finds nothing gives one
// empty result like the single-result requests. Results appear for one cycle
// with rsp_valid and cannot be held off, so the receiver must take every one.
// The byte memory needs no clearing pass after reset.
module byte_ring_fifo_peek_skip #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bfps_pkg::req_type   req_data,
   output logic                busy,
   output logic                rsp_valid,
   output bfps_pkg::rsp_type   rsp_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = AW + 1;
   localparam int CW    = (PW > bfps_pkg::OFF_W) ? PW : bfps_pkg::OFF_W;
   localparam int CNT_W = bfps_pkg::CNT_W;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic [PW-1:0]       rp_ff, rp_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bfps_pkg::rsp_type   meta_ff, meta_in;

   logic                accept;
   logic [PW-1:0]       lvl_now;
   logic [PW-1:0]       lvl_next;
   logic [CW-1:0]       lvl_cw;
   logic [CW-1:0]       off_cw;
   logic [CW-1:0]       avail;
   logic [CW-1:0]       psum;
   logic [CNT_W-1:0]    cnt_c;
   logic [CNT_W-1:0]    get_n;
   logic [CNT_W-1:0]    peek_n;
   logic [CNT_W-1:0]    skip_n;
   logic [CNT_W-1:0]    done_n;
   logic                full;
   logic                burst_go;

   logic                mem_wr_en;
   logic                mem_rd_en;
   bfps_pkg::data_type  mem_rd_data;

   assign busy    = (state_ff == ST_BURST);
   assign accept  = start && !busy;
   assign lvl_now = wp_ff - rp_ff;
   assign lvl_cw  = CW'(lvl_now);
   assign off_cw  = CW'(req_data.offset);
   assign full    = (lvl_now == PW'(DEPTH));
   assign avail   = lvl_cw - off_cw;
   assign psum    = CW'(rp_ff[AW-1:0]) + off_cw;

   always_comb begin
      cnt_c  = (req_data.count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : req_data.count;
      get_n  = (CW'(cnt_c) < lvl_cw) ? cnt_c : CNT_W'(lvl_now);
      skip_n = (CW'(req_data.count) < lvl_cw) ? req_data.count : CNT_W'(lvl_now);
      if (off_cw < lvl_cw) begin
         peek_n = (CW'(cnt_c) < avail) ? cnt_c : CNT_W'(avail);
      end else begin
         peek_n = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      meta_in      = meta_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      done_n       = '0;
      burst_go     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  bfps_pkg::CMD_PUT: begin
                     if (!full) begin
                        mem_wr_en = 1'b1;
                        wp_in     = wp_ff + PW'(1);
                        done_n    = CNT_W'(1);
                     end
                  end
                  bfps_pkg::CMD_GET: begin
                     if (get_n != '0) begin
                        burst_go = 1'b1;
                        done_n   = get_n;
                        rp_in    = rp_ff + PW'(get_n);
                        addr_in  = rp_ff[AW-1:0];
                     end
                  end
                  bfps_pkg::CMD_PEEK: begin
                     if (peek_n != '0) begin
                        burst_go = 1'b1;
                        done_n   = peek_n;
                        addr_in  = psum[AW-1:0];
                     end
                  end
                  bfps_pkg::CMD_SKIP: begin
                     done_n = skip_n;
                     rp_in  = rp_ff + PW'(skip_n);
                  end
                  bfps_pkg::CMD_RESET: begin
                     wp_in = '0;
                     rp_in = '0;
                  end
                  default: begin
                     // status query and unused codes change nothing
                  end
               endcase

               if (burst_go) begin
                  state_in = ST_BURST;
                  left_in  = done_n;
                  n_in     = done_n;
               end else begin
                  rsp_valid_in       = 1'b1;
                  meta_in.data_valid = 1'b0;
                  meta_in.last       = 1'b1;
                  meta_in.done_count = done_n;
               end
            end
         end
         ST_BURST: begin
            // busy blocks puts, so a burst read never meets a write
            mem_rd_en          = 1'b1;
            addr_in            = addr_ff + AW'(1);
            left_in            = left_ff - CNT_W'(1);
            rsp_valid_in       = 1'b1;
            meta_in.data_valid = 1'b1;
            meta_in.last       = (left_ff == CNT_W'(1));
            meta_in.done_count = n_ff;
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      lvl_next         = wp_in - rp_in;
      meta_in.data_out = '0;
      meta_in.level    = bfps_pkg::level_type'(lvl_next);
      if (lvl_next == '0) begin
         meta_in.fill_state = bfps_pkg::FILL_EMPTY;
      end else if (lvl_next == PW'(DEPTH)) begin
         meta_in.fill_state = bfps_pkg::FILL_FULL;
      end else begin
         meta_in.fill_state = bfps_pkg::FILL_PARTIAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
      addr_ff <= addr_in;
      n_ff    <= n_in;
      meta_ff <= meta_in;
   end

   bfps_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (req_data.data_in),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data          = meta_ff;
      rsp_data.data_out = meta_ff.data_valid ? mem_rd_data : '0;
   end

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && !burst_go |=> rsp_valid && rsp_data.last && !rsp_data.data_valid)
      else $error("single-result request gave no final result");

   a_burst_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && rsp_data.data_valid)
      else $error("burst cycle gave no data result");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("burst ended before its last byte");

   a_no_write_in_burst: assert property (@(posedge clock) disable iff (reset)
      busy |-> !mem_wr_en)
      else $error("memory write during burst read");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      $past(accept) && $past(req_data.command) == bfps_pkg::CMD_PUT && $past(full)
      |-> wp_ff == $past(wp_ff))
      else $error("put stored a byte into a full FIFO");

endmodule

// File: design/bfps_store.sv
// Byte memory: one write port, one read port with registered read data.
module bfps_store #(
   parameter int AW = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  bfps_pkg::data_type       wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output bfps_pkg::data_type       rd_data
);

   bfps_pkg::data_type mem [2**AW];
   bfps_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
